// ===== sv/bm25_pkg.sv =====
// Package: shared constants and types for the BM25 top-k scoring block.
`timescale 1ns / 1ps
package bm25_pkg;
  localparam int TOP_K = 3;
  localparam int TOP_W = $clog2(TOP_K + 1);
  localparam int RANK_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_AVG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B = 2'd2;
  localparam int DIV_W = 64;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_LOAD, CMD_RATIO, CMD_NORM, CMD_DEN, CMD_NUM, CMD_QUOT, CMD_ACC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_start;
    logic   insert;
    logic   clear;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic skip;
  } dp_stat_t;
endpackage

// ===== sv/bm25_div.sv =====
// Divider: restoring, one quotient bit per cycle.
`timescale 1ns / 1ps
module bm25_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bm25_pkg::DIV_W-1:0] dividend,
  input  logic [bm25_pkg::DIV_W-1:0] divisor,
  output logic                       busy,
  output logic [bm25_pkg::DIV_W-1:0] quotient
);
  localparam int CW = $clog2(bm25_pkg::DIV_W + 1);
  logic [bm25_pkg::DIV_W-1:0] rem, dvs;
  logic [CW-1:0] count;
  logic [bm25_pkg::DIV_W:0] trial;

  always_comb begin
    trial = {rem, quotient[bm25_pkg::DIV_W-1]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CW'(bm25_pkg::DIV_W);
      rem <= '0;
      dvs <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (trial[bm25_pkg::DIV_W]) begin
        rem <= {rem[bm25_pkg::DIV_W-2:0], quotient[bm25_pkg::DIV_W-1]};
        quotient <= {quotient[bm25_pkg::DIV_W-2:0], 1'b0};
      end else begin
        rem <= trial[bm25_pkg::DIV_W-1:0];
        quotient <= {quotient[bm25_pkg::DIV_W-2:0], 1'b1};
      end
      count <= count - 1'b1;
      if (count == CW'(1)) busy <= 1'b0;
    end
  end
endmodule

// ===== sv/bm25_datapath.sv =====
// Datapath: term score arithmetic, running sum and top-k table.
`timescale 1ns / 1ps
module bm25_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  bm25_pkg::dp_cmd_t    cmd,
  output bm25_pkg::dp_stat_t   stat,
  input  logic [23:0]          avg_q8,
  input  logic [9:0]           k1_q8,
  input  logic [8:0]           b_q8,
  input  logic [15:0]          doc_id,
  input  logic [15:0]          doc_len,
  input  logic [15:0]          term_freq,
  input  logic signed [15:0]   idf_q12,
  input  logic [bm25_pkg::TOP_W-1:0] rd_sel,
  output logic [15:0]          rd_doc,
  output logic signed [31:0]   rd_score,
  output logic [bm25_pkg::TOP_W-1:0] n_valid
);
  localparam int K = bm25_pkg::TOP_K;
  logic [15:0] len_r, tf_r, id_r, mag;
  logic neg;
  logic [8:0] b_sat;
  logic [23:0] avg_eff;
  logic [63:0] acc, div_a, div_b, quot;
  logic [63:0] den;
  logic signed [31:0] run;
  logic div_go;
  logic busy;
  logic [15:0] tdoc [K];
  logic signed [31:0] tscore [K];
  logic [K-1:0] tval;
  logic signed [33:0] sum;
  logic [K-1:0] beat;
  logic [31:0] ins_score;

  assign b_sat = (b_q8 > 9'd256) ? 9'd256 : b_q8;
  assign avg_eff = (avg_q8 == '0) ? 24'd1 : avg_q8;
  assign stat.div_busy = busy | div_go;
  assign stat.skip = (tf_r == '0) || (den == '0);

  always_comb begin
    div_a = '0;
    div_b = '0;
    unique case (cmd.op)
      bm25_pkg::CMD_RATIO: begin
        div_a = {16'd0, len_r, 32'd0} >> 16;
        div_b = {40'd0, avg_eff};
      end
      default: begin
        div_a = acc;
        div_b = den;
      end
    endcase
  end

  bm25_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a),
    .divisor(div_b), .busy(busy), .quotient(quot)
  );

  always_comb begin
    if (neg) sum = 34'(run) - 34'(signed'({1'b0, quot[32:0]}));
    else sum = 34'(run) + 34'(signed'({1'b0, quot[32:0]}));
    if (quot[63:33] != '0) sum = neg ? -34'sd8589934591 : 34'sd8589934591;
  end

  assign ins_score = run;
  always_comb begin
    for (int i = 0; i < K; i++)
      beat[i] = !tval[i] || (tscore[i] < signed'(ins_score));
  end

  always_comb begin
    n_valid = '0;
    for (int i = 0; i < K; i++) if (tval[i]) n_valid = bm25_pkg::TOP_W'(i + 1);
    rd_doc = '0;
    rd_score = '0;
    for (int i = 0; i < K; i++)
      if (rd_sel == bm25_pkg::TOP_W'(i)) begin
        rd_doc = tdoc[i];
        rd_score = tscore[i];
      end
  end

  always_ff @(posedge clk) begin
    div_go <= cmd.div_start;
    unique case (cmd.op)
      bm25_pkg::CMD_LOAD: begin
        len_r <= doc_len;
        tf_r <= term_freq;
        id_r <= doc_id;
        neg <= idf_q12[15];
        mag <= idf_q12[15] ? 16'(-idf_q12) : idf_q12;
      end
      bm25_pkg::CMD_NORM:
        acc <= 64'({16'd256 - 16'(b_sat), 8'd0}) + 64'(b_sat) * quot[31:0];
      bm25_pkg::CMD_DEN:
        den <= {24'd0, tf_r, 24'd0} + {14'd0, 50'(k1_q8) * 50'(acc[39:0])};
      bm25_pkg::CMD_NUM: acc <= {64'(32'(mag) * 32'(tf_r))};
      bm25_pkg::CMD_QUOT:
        acc <= {5'd0, 43'(acc[31:0]) * 43'(k1_q8 + 11'd256), 16'd0};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      run <= '0;
      tval <= '0;
      for (int i = 0; i < K; i++) begin
        tdoc[i] <= '0;
        tscore[i] <= '0;
      end
    end else begin
      if (cmd.op == bm25_pkg::CMD_ACC) begin
        if (sum > 34'sd2147483647) run <= 32'sh7fffffff;
        else if (sum < -34'sd2147483648) run <= 32'sh80000000;
        else run <= sum[31:0];
      end
      if (cmd.insert) begin
        run <= '0;
        for (int i = 0; i < K; i++) begin
          if (beat[i]) begin
            if (i == 0 || !beat[i-1 < 0 ? 0 : i-1]) begin
              tdoc[i] <= id_r;
              tscore[i] <= ins_score;
              tval[i] <= 1'b1;
            end else begin
              tdoc[i] <= tdoc[i-1 < 0 ? 0 : i-1];
              tscore[i] <= tscore[i-1 < 0 ? 0 : i-1];
              tval[i] <= tval[i-1 < 0 ? 0 : i-1];
            end
          end
        end
      end
    end
  end
endmodule

// ===== sv/bm25_ctrl.sv =====
// Controller: sequences one term through the datapath and drains the ranking.
`timescale 1ns / 1ps
module bm25_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               last_term,
  input  logic               last_doc,
  output bm25_pkg::dp_cmd_t  cmd,
  input  bm25_pkg::dp_stat_t stat,
  input  logic [bm25_pkg::TOP_W-1:0] n_valid,
  output logic [bm25_pkg::TOP_W-1:0] rd_sel,
  output logic               out_load,
  output logic               out_last,
  input  logic               out_full
);
  typedef enum logic [3:0] {
    S_IDLE, S_RATIO, S_RW, S_NORM, S_DEN, S_NUM, S_QUOT, S_QW, S_ACC, S_INS, S_EMIT, S_CLR
  } state_t;
  state_t state;
  logic lt_r, ld_r;
  logic qstart;

  assign in_stall = (state != S_IDLE);
  assign out_last = (rd_sel == n_valid - 1'b1);
  assign out_load = (state == S_EMIT) && !out_full && (rd_sel < n_valid);

  always_comb begin
    cmd = '{op: bm25_pkg::CMD_NONE, div_start: 1'b0, insert: 1'b0, clear: 1'b0};
    unique case (state)
      S_IDLE: if (in_valid) cmd.op = bm25_pkg::CMD_LOAD;
      S_RATIO: begin
        cmd.op = bm25_pkg::CMD_RATIO;
        cmd.div_start = 1'b1;
      end
      S_NORM: cmd.op = bm25_pkg::CMD_NORM;
      S_DEN: cmd.op = bm25_pkg::CMD_DEN;
      S_NUM: cmd.op = bm25_pkg::CMD_NUM;
      S_QUOT: begin
        cmd.op = bm25_pkg::CMD_QUOT;
      end
      S_QW: cmd.div_start = qstart && !stat.skip;
      S_ACC: cmd.op = bm25_pkg::CMD_ACC;
      S_INS: cmd.insert = 1'b1;
      S_CLR: cmd.clear = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_sel <= '0;
      qstart <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          lt_r <= last_term;
          ld_r <= last_doc;
          state <= S_RATIO;
        end
        S_RATIO: state <= S_RW;
        S_RW: if (!stat.div_busy) state <= S_NORM;
        S_NORM: state <= S_DEN;
        S_DEN: state <= S_NUM;
        S_NUM: state <= S_QUOT;
        S_QUOT: begin
          state <= S_QW;
          qstart <= 1'b1;
        end
        S_QW: begin
          qstart <= 1'b0;
          if (!qstart && !stat.div_busy) begin
            if (stat.skip) state <= lt_r ? S_INS : S_IDLE;
            else state <= S_ACC;
          end
        end
        S_ACC: state <= lt_r ? S_INS : S_IDLE;
        S_INS: begin
          rd_sel <= '0;
          state <= ld_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (rd_sel >= n_valid) state <= S_CLR;
          else if (!out_full) rd_sel <= rd_sel + 1'b1;
        end
        S_CLR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/bm25_score_top_k_core.sv =====
// Top level: BM25 term scoring with a top-3 ranking table.
// Input channel: one beat per query term (doc_id, doc_len, term_freq,
//   idf_q12, last_term, last_doc), accepted when in_valid and !in_stall.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; write
//   only while idle. Index 0 avg length, 1 k1, 2 b.
// Output channel: one beat per ranked document (rank, best_doc, best_score,
//   last_result), taken when out_valid and !out_stall.
// A term holds the input from acceptance through two passes of the shared
//   restoring divider (len/avgdl, then the term quotient). A term with zero
//   frequency or a zero denominator skips the second pass; a last_term adds
//   the table insert state.
// A last_doc term that is also a last_term adds the table drain, one beat per cycle while the
//   receiver does not stall; a stall holds the output register and the drain.
// Reset clears the running score, the table and restores register defaults.
`timescale 1ns / 1ps
module bm25_score_top_k_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         doc_id,
  input  logic [15:0]         doc_len,
  input  logic [15:0]         term_freq,
  input  logic signed [15:0]  idf_q12,
  input  logic                last_term,
  input  logic                last_doc,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          rank,
  output logic [15:0]         best_doc,
  output logic signed [31:0]  best_score,
  output logic                last_result
);
  bm25_pkg::dp_cmd_t cmd;
  bm25_pkg::dp_stat_t stat;
  logic [23:0] avg_q8;
  logic [9:0] k1_q8;
  logic [8:0] b_q8;
  logic [bm25_pkg::TOP_W-1:0] rd_sel, n_valid;
  logic [15:0] rd_doc;
  logic signed [31:0] rd_score;
  logic out_load, out_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_q8 <= 24'd256;
      k1_q8 <= 10'd384;
      b_q8 <= 9'd192;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bm25_pkg::REG_AVG: avg_q8 <= cfg_data;
        bm25_pkg::REG_K1: k1_q8 <= cfg_data[9:0];
        bm25_pkg::REG_B: b_q8 <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  bm25_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .last_term(last_term), .last_doc(last_doc), .cmd(cmd), .stat(stat),
    .n_valid(n_valid), .rd_sel(rd_sel), .out_load(out_load),
    .out_last(out_last), .out_full(out_valid && out_stall)
  );

  bm25_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .avg_q8(avg_q8),
    .k1_q8(k1_q8), .b_q8(b_q8), .doc_id(doc_id), .doc_len(doc_len),
    .term_freq(term_freq), .idf_q12(idf_q12), .rd_sel(rd_sel),
    .rd_doc(rd_doc), .rd_score(rd_score), .n_valid(n_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      rank <= bm25_pkg::RANK_W'(rd_sel);
      best_doc <= rd_doc;
      best_score <= rd_score;
      last_result <= out_last;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
endmodule

// ===== sv/bm25_checker.sv =====
// Checker: port-level assertions for the BM25 core, bound to the top level.
`timescale 1ns / 1ps
module bm25_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  rank,
  input logic        last_result
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rank))
    else $error("stalled beat changed");
  a_rank0: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_result |=> !out_valid || rank == 2'd0)
    else $error("ranking not restarted");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after a beat");
endmodule

bind bm25_score_top_k_core bm25_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .rank(rank),
  .last_result(last_result)
);

// ===== test/bm25_score_checker.sv =====
// Checker: watches the BM25 block's channels, predicts the ranking beats and compares them.
`timescale 1ns / 1ps
module bm25_score_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        doc_id,
  input  logic [15:0]        doc_len,
  input  logic [15:0]        term_freq,
  input  logic signed [15:0] idf_q12,
  input  logic               last_term,
  input  logic               last_doc,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         rank,
  input  logic [15:0]        best_doc,
  input  logic signed [31:0] best_score,
  input  logic               last_result,
  output int                 errors,
  output int                 pending
);
  typedef struct packed {
    logic [1:0]         rank;
    logic [15:0]        doc;
    logic signed [31:0] score;
    logic               last;
  } ranking_t;

  ranking_t         ranking_q[$];
  logic [23:0]      avg_len;
  logic [9:0]       k1;
  logic [8:0]       b_wt;
  logic signed [31:0] doc_sum;
  logic [15:0]      tbl_doc[bm25_pkg::TOP_K];
  logic signed [31:0] tbl_score[bm25_pkg::TOP_K];
  logic             tbl_ok[bm25_pkg::TOP_K];

  assign pending = ranking_q.size();

  function automatic longint bm25_term(logic [15:0] len, logic [15:0] tf,
                                       logic [15:0] idf);
    logic [63:0] avg, ratio, norm, den, num, mag, q;
    logic [8:0]  bb;
    if (tf == 0) return 0;
    avg = (avg_len == 0) ? 64'd1 : 64'(avg_len);
    bb = (b_wt > 9'd256) ? 9'd256 : b_wt;
    ratio = (64'(len) << 16) / avg;
    norm = (64'(9'd256 - bb) << 8) + 64'(bb) * ratio;
    den = (64'(tf) << 24) + 64'(k1) * norm;
    if (den == 0) return 0;
    mag = idf[15] ? 64'(17'h10000 - idf) : 64'(idf);
    num = (mag * 64'(tf) * 64'(k1 + 11'd256)) << 16;
    q = num / den;
    return idf[15] ? -longint'(q) : longint'(q);
  endfunction

  task automatic clear_table();
    doc_sum = 0;
    for (int i = 0; i < bm25_pkg::TOP_K; i++) begin
      tbl_doc[i] = 0;
      tbl_score[i] = 0;
      tbl_ok[i] = 0;
    end
  endtask

  task automatic score_term();
    longint s;
    int pos, n;
    ranking_t r;
    s = longint'(doc_sum) + bm25_term(doc_len, term_freq, idf_q12);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    doc_sum = s[31:0];
    if (!last_term) return;
    pos = 0;
    while (pos < bm25_pkg::TOP_K && tbl_ok[pos] && tbl_score[pos] >= doc_sum) pos++;
    if (pos < bm25_pkg::TOP_K) begin
      for (int i = bm25_pkg::TOP_K - 1; i > pos; i--) begin
        tbl_doc[i] = tbl_doc[i-1];
        tbl_score[i] = tbl_score[i-1];
        tbl_ok[i] = tbl_ok[i-1];
      end
      tbl_doc[pos] = doc_id;
      tbl_score[pos] = doc_sum;
      tbl_ok[pos] = 1;
    end
    doc_sum = 0;
    if (!last_doc) return;
    n = 0;
    while (n < bm25_pkg::TOP_K && tbl_ok[n]) n++;
    for (int k = 0; k < n; k++) begin
      r.rank = k[1:0];
      r.doc = tbl_doc[k];
      r.score = tbl_score[k];
      r.last = (k == n - 1);
      ranking_q = {ranking_q, r};
    end
    clear_table();
  endtask

  always @(posedge clk) begin
    ranking_t e;
    if (rst) begin
      avg_len <= 24'd256;
      k1 <= 10'd384;
      b_wt <= 9'd192;
      clear_table();
      ranking_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bm25_pkg::REG_AVG: avg_len <= cfg_data;
          bm25_pkg::REG_K1: k1 <= cfg_data[9:0];
          bm25_pkg::REG_B: b_wt <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) score_term();
      if (out_valid && !out_stall) begin
        if (ranking_q.size() == 0) begin
          if (errors < 10) $display("unexpected beat: rank %0d doc %0d score %0d",
                                    rank, best_doc, best_score);
          errors <= errors + 1;
        end else begin
          e = ranking_q.pop_front();
          if (e.rank !== rank || e.doc !== best_doc || e.score !== best_score ||
              e.last !== last_result) begin
            if (errors < 10)
              $display("mismatch: exp rank %0d doc %0d score %0d last %0b, got %0d %0d %0d %0b",
                       e.rank, e.doc, e.score, e.last, rank, best_doc, best_score,
                       last_result);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb.sv =====
// Testbench top: drives terms, config writes and output stalls for the BM25 top-k block.
`timescale 1ns / 1ps
module tb;
  localparam logic [1:0] REG_NONE = 2'd3;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 0;
  logic [23:0]        cfg_data = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [15:0]        doc_id = 0;
  logic [15:0]        doc_len = 0;
  logic [15:0]        term_freq = 0;
  logic signed [15:0] idf_q12 = 0;
  logic               last_term = 0;
  logic               last_doc = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [1:0]         rank;
  logic [15:0]        best_doc;
  logic signed [31:0] best_score;
  logic               last_result;
  int                 errors;
  int                 pending;
  int                 rx_wait = 0;
  bit                 hold_out = 0;
  bit                 stim_done = 0;

  always #1 clk = ~clk;

  bm25_score_top_k_core dut (.*);
  bm25_score_checker chk (.*);

  task automatic send_term(logic [15:0] id, logic [15:0] len, logic [15:0] tf,
                           logic [15:0] idf, bit lt, bit ld);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    cfg_valid <= 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    doc_id <= id;
    doc_len <= len;
    term_freq <= tf;
    idf_q12 <= idf;
    last_term <= lt;
    last_doc <= ld;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
  endtask

  task automatic random_query(int docs, int terms_max);
    logic [15:0] id;
    int nt;
    for (int d = 0; d < docs; d++) begin
      id = 16'($urandom);
      nt = $urandom_range(1, terms_max);
      for (int t = 0; t < nt; t++) begin
        if ($urandom_range(0, 9) == 0) id = 16'($urandom);
        send_term(id, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600)),
                  ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)),
                  16'($urandom), t == nt - 1,
                  (d == docs - 1 && t == nt - 1) || $urandom_range(0, 15) == 0);
      end
    end
  endtask

  always @(posedge clk) begin
    int w;
    if (hold_out) begin
      out_stall <= 1;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end else if (out_valid && !out_stall) begin
      w = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) w = 0;
      rx_wait <= w;
      out_stall <= (w != 0);
    end else begin
      out_stall <= 0;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, saturation, zero frequency, ties
    send_term(16'd1, 16'd0, 16'd0, 16'h7fff, 1, 0);
    send_term(16'd2, 16'hffff, 16'hffff, 16'h7fff, 0, 0);
    send_term(16'd9, 16'd10, 16'd1, 16'h8000, 1, 0);
    send_term(16'hffff, 16'd100, 16'd3, 16'h1000, 1, 0);
    send_term(16'd5, 16'd100, 16'd3, 16'h1000, 1, 0);
    send_term(16'd6, 16'd50, 16'd2, 16'hffff, 0, 1);
    send_term(16'd6, 16'd50, 16'd2, 16'h8000, 1, 1);
    drain();
    write_reg(bm25_pkg::REG_AVG, 24'd0);
    write_reg(bm25_pkg::REG_K1, 24'd0);
    write_reg(bm25_pkg::REG_B, 24'h1ff);
    write_reg(REG_NONE, 24'hffffff);
    send_term(16'd7, 16'd0, 16'd1, 16'h7fff, 1, 0);
    send_term(16'd8, 16'hffff, 16'd1, 16'h0001, 1, 1);
    drain();
    write_reg(bm25_pkg::REG_AVG, 24'hffffff);
    write_reg(bm25_pkg::REG_K1, 24'h3ff);
    write_reg(bm25_pkg::REG_B, 24'd0);
    for (int i = 0; i < 8; i++)
      send_term(16'(i), 16'hffff, 16'hffff, 16'h7fff, i % 2 == 1, i == 7);
    drain();
    write_reg(bm25_pkg::REG_AVG, 24'd256);
    write_reg(bm25_pkg::REG_K1, 24'd384);
    write_reg(bm25_pkg::REG_B, 24'd256);
    fork
      begin
        hold_out = 1;
        repeat (3000) @(posedge clk);
        hold_out = 0;
      end
      random_query(4, 2);
    join
    random_query(3, 3);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(bm25_pkg::REG_AVG, 24'($urandom_range(1, 24'hffffff)));
      write_reg(bm25_pkg::REG_K1, 24'($urandom_range(0, 1023)));
      write_reg(bm25_pkg::REG_B, 24'($urandom_range(0, 256)));
      for (int q = 0; q < 11; q++) random_query($urandom_range(1, 5), 4);
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end
endmodule
